>>> hdl/text_console_cursor_engine_assert.svh
// assertion macros shared by the console cursor engine modules
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TCCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tcce_pkg.sv
// types, codes and helper functions of the console cursor engine
`timescale 1ns / 1ps

package tcce_pkg;

  // field widths
  localparam int COL_W   = 8;
  localparam int ROW_W   = 7;
  localparam int GLYPH_W = 7;
  localparam int FB_W    = 10;
  localparam int PIX_W   = 12;

  // op queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // register reset values
  localparam logic [COL_W-1:0] COLS_RESET   = 8'd128;
  localparam logic [ROW_W-1:0] ROWS_RESET   = 7'd76;
  localparam logic [FB_W-1:0]  HEIGHT_RESET = 10'd768;

  // character codes
  localparam logic [7:0] CH_BACKSPACE   = 8'h08;
  localparam logic [7:0] CH_TAB         = 8'h09;
  localparam logic [7:0] CH_NEWLINE     = 8'h0A;
  localparam logic [7:0] CH_RETURN      = 8'h0D;
  localparam logic [7:0] CH_FIRST_PRINT = 8'd32;
  localparam logic [7:0] CH_LAST_PRINT  = 8'd126;
  localparam logic [8:0] TAB_MASK       = ~9'd7;
  localparam logic [8:0] TAB_STEP       = 9'd8;

  typedef enum logic [1:0] {
    FUNC_CHAR    = 2'd0,
    FUNC_FLUSH   = 2'd1,
    FUNC_SUSPEND = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_TEXT_COLUMNS = 2'd0,
    CFG_TEXT_ROWS    = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_DRAW   = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_NOP       = 3'd0,
    OP_SUSPEND   = 3'd1,
    OP_FLUSH     = 3'd2,
    OP_NEWLINE   = 3'd3,
    OP_RETURN    = 3'd4,
    OP_BACKSPACE = 3'd5,
    OP_TAB       = 3'd6,
    OP_PRINT     = 3'd7
  } op_code_t;

  // classified word handed from front to back
  typedef struct packed {
    op_code_t             code;
    logic [GLYPH_W-1:0]   glyph;
    logic                 on;
  } op_t;

  // one result word
  typedef struct packed {
    kind_t                kind;
    logic [ROW_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic [GLYPH_W-1:0]   glyph;
    logic [FB_W-1:0]      top;
    logic [FB_W-1:0]      bottom;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic [FB_W-1:0]  top;
    logic [FB_W-1:0]  bottom;
  } dirty_t;

  // widen the dirty range by pixel rows y0 up to y1, clamped to the frame height
  function automatic dirty_t mark_rows(dirty_t d, logic [PIX_W-1:0] y0,
                                       logic [PIX_W-1:0] y1, logic [FB_W-1:0] fh);
    dirty_t r;
    logic [PIX_W-1:0] fh_w;
    logic [PIX_W-1:0] y1c;
    r    = d;
    fh_w = {{(PIX_W-FB_W){1'b0}}, fh};
    y1c  = (y1 > fh_w) ? fh_w : y1;
    if (y0 < y1c) begin
      if (!d.valid) begin
        r.valid  = 1'b1;
        r.top    = y0[FB_W-1:0];
        r.bottom = y1c[FB_W-1:0];
      end else begin
        if (y0 < {{(PIX_W-FB_W){1'b0}}, d.top}) r.top = y0[FB_W-1:0];
        if (y1c > {{(PIX_W-FB_W){1'b0}}, d.bottom}) r.bottom = y1c[FB_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/tcce_front.sv
// front end: input register and classification of incoming words
`timescale 1ns / 1ps

module tcce_front
  import tcce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // char_code [7:0], suspend_on [8], zero fill
  input  logic [1:0]  s_tuser,   // func [1:0]
  output logic        op_valid,
  input  logic        op_ready,
  output op_t         op
);

  op_t  op_class;
  logic front_valid;
  op_t  front_op;

  // decode the incoming word into an operation
  always_comb begin
    logic [7:0] c;
    c = s_tdata[7:0];
    op_class.code  = OP_NOP;
    op_class.glyph = GLYPH_W'(c - CH_FIRST_PRINT);
    op_class.on    = s_tdata[8];
    unique case (func_t'(s_tuser))
      FUNC_SUSPEND: op_class.code = OP_SUSPEND;
      FUNC_FLUSH:   op_class.code = OP_FLUSH;
      FUNC_CHAR: begin
        if (c == CH_NEWLINE)        op_class.code = OP_NEWLINE;
        else if (c == CH_RETURN)    op_class.code = OP_RETURN;
        else if (c == CH_BACKSPACE) op_class.code = OP_BACKSPACE;
        else if (c == CH_TAB)       op_class.code = OP_TAB;
        else if (c >= CH_FIRST_PRINT && c <= CH_LAST_PRINT) op_class.code = OP_PRINT;
      end
      default: op_class.code = OP_NOP;
    endcase
  end

  // take a word whenever the register is empty or draining into the queue
  assign s_tready = !front_valid || op_ready;
  assign op_valid = front_valid;
  assign op       = front_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      // words that do nothing are dropped here
      front_valid <= (op_class.code != OP_NOP);
    end else if (op_ready) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      front_op <= op_class;
    end
  end

endmodule

>>> hdl/tcce_queue.sv
// short op queue decoupling the front end from the back end
`timescale 1ns / 1ps

module tcce_queue
  import tcce_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  op_t  in_op,
  output logic out_valid,
  input  logic out_ready,
  output op_t  out_op
);

`include "text_console_cursor_engine_assert.svh"

  op_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_op    = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_op;
    end
  end

  `TCCE_ASSERT_NEXT(a_queue_drain, pop && !push, count == $past(count) - 1'b1, "queue count did not drop on pop")
  `TCCE_ASSERT_NOW(a_queue_bound, 1'b1, count <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

>>> hdl/tcce_back.sv
// back end: cursor state, dirty range, configuration and result output
`timescale 1ns / 1ps

module tcce_back
  import tcce_pkg::*;
#(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 76,
  parameter int CELL_HEIGHT = 10,
  parameter int HEADER_ROWS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        q_valid,
  output logic        q_ready,
  input  op_t         q_op,
  output logic        m_tvalid,
  input  logic        m_tready,
  output res_t        m_res
);

`include "text_console_cursor_engine_assert.svh"

  localparam logic [COL_W-1:0] MaxCols = COL_W'(MAX_COLUMNS);
  localparam logic [ROW_W-1:0] MaxRows = ROW_W'(MAX_ROWS);
  localparam logic [PIX_W-1:0] CellH   = PIX_W'(CELL_HEIGHT);
  localparam logic [ROW_W-1:0] HomeRow = ROW_W'(HEADER_ROWS);

  // configuration registers
  logic [COL_W-1:0] text_columns;
  logic [ROW_W-1:0] text_rows;
  logic [FB_W-1:0]  frame_height;

  // cursor and dirty state
  logic [COL_W-1:0] cursor_column;
  logic [ROW_W-1:0] cursor_row;
  logic             suspended;
  dirty_t           dirty;

  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic             suspended_next;
  dirty_t           dirty_next;

  // output register and spill stage for the second result
  logic out_valid;
  res_t out_res;
  logic spill_valid;
  res_t spill_res;

  res_t       res0;
  res_t       res1;
  logic [1:0] n_res;
  logic       pop;
  logic       out_free;

  logic [COL_W-1:0] cols_eff;
  logic [ROW_W-1:0] rows_eff;
  logic [COL_W:0]   row_inc;
  logic             nl_scroll;
  logic [PIX_W-1:0] draw_y0;
  logic [PIX_W-1:0] draw_y1;
  logic [PIX_W-1:0] scroll_y1;
  logic [COL_W:0]   col_inc;
  logic [COL_W:0]   tab_target;
  dirty_t           dirty_draw;
  dirty_t           dirty_scroll;
  dirty_t           dirty_draw_scroll;

  // effective grid size
  always_comb begin
    cols_eff = (text_columns > MaxCols) ? MaxCols : text_columns;
    if (cols_eff == '0) cols_eff = COL_W'(1);
    rows_eff = (text_rows > MaxRows) ? MaxRows : text_rows;
    if (rows_eff == '0) rows_eff = ROW_W'(1);
  end

  // cursor arithmetic shared by the operations
  assign row_inc    = {2'b00, cursor_row} + 1'b1;
  assign nl_scroll  = row_inc >= {2'b00, rows_eff};
  assign col_inc    = {1'b0, cursor_column} + 1'b1;
  assign tab_target = ({1'b0, cursor_column} + TAB_STEP) & TAB_MASK;
  assign draw_y0    = PIX_W'({{(PIX_W-ROW_W){1'b0}}, cursor_row} * CellH);
  assign draw_y1    = draw_y0 + CellH;
  assign scroll_y1  = PIX_W'({{(PIX_W-ROW_W){1'b0}}, rows_eff} * CellH);

  // dirty range after a draw, a scroll, or both in order
  assign dirty_draw        = mark_rows(dirty, draw_y0, draw_y1, frame_height);
  assign dirty_scroll      = mark_rows(dirty, '0, scroll_y1, frame_height);
  assign dirty_draw_scroll = mark_rows(dirty_draw, '0, scroll_y1, frame_height);

  // execute one operation
  always_comb begin
    col_next       = cursor_column;
    row_next       = cursor_row;
    suspended_next = suspended;
    dirty_next     = dirty;
    res0           = '0;
    res1           = '0;
    n_res          = 2'd0;
    unique case (q_op.code) inside
      OP_SUSPEND: begin
        suspended_next = q_op.on;
        if (q_op.on) dirty_next.valid = 1'b0;
      end
      OP_FLUSH: begin
        if (!suspended && dirty.valid) begin
          res0.kind   = KIND_FLUSH;
          res0.top    = dirty.top;
          res0.bottom = dirty.bottom;
          n_res       = 2'd1;
        end
        dirty_next.valid = 1'b0;
      end
      OP_NEWLINE, OP_TAB: begin
        if (!suspended) begin
          if (q_op.code == OP_TAB && tab_target < {1'b0, cols_eff}) begin
            col_next = tab_target[COL_W-1:0];
          end else begin
            col_next = '0;
            if (nl_scroll) begin
              res0.kind  = KIND_SCROLL;
              n_res      = 2'd1;
              dirty_next = dirty_scroll;
              row_next   = rows_eff - 1'b1;
            end else begin
              row_next = row_inc[ROW_W-1:0];
            end
          end
        end
      end
      OP_RETURN: begin
        if (!suspended) col_next = '0;
      end
      OP_BACKSPACE: begin
        if (!suspended && cursor_column != '0) begin
          col_next   = cursor_column - 1'b1;
          res0.kind  = KIND_DRAW;
          res0.col   = col_next[ROW_W-1:0];
          res0.row   = cursor_row;
          n_res      = 2'd1;
          dirty_next = dirty_draw;
        end
      end
      OP_PRINT: begin
        if (!suspended) begin
          res0.kind  = KIND_DRAW;
          res0.col   = cursor_column[ROW_W-1:0];
          res0.row   = cursor_row;
          res0.glyph = q_op.glyph;
          n_res      = 2'd1;
          dirty_next = dirty_draw;
          if (col_inc >= {1'b0, cols_eff}) begin
            // wrap at the end of the line, scrolling at the last row
            col_next = '0;
            if (nl_scroll) begin
              res1.kind  = KIND_SCROLL;
              n_res      = 2'd2;
              dirty_next = dirty_draw_scroll;
              row_next   = rows_eff - 1'b1;
            end else begin
              row_next = row_inc[ROW_W-1:0];
            end
          end else begin
            col_next = col_inc[COL_W-1:0];
          end
        end
      end
      default: ;
    endcase
    if (n_res == 2'd1) res0.last = 1'b1;
    if (n_res == 2'd2) res1.last = 1'b1;
  end

  // handshake with the queue and the output
  assign out_free  = !out_valid || m_tready;
  assign q_ready   = !spill_valid && out_free;
  assign pop       = q_valid && q_ready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_res     = out_res;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      text_columns <= COLS_RESET;
      text_rows    <= ROWS_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TEXT_COLUMNS: text_columns <= cfg_data[COL_W-1:0];
        CFG_TEXT_ROWS:    text_rows    <= cfg_data[ROW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // cursor and dirty state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= HomeRow;
      suspended     <= 1'b0;
      dirty         <= '0;
    end else if (pop) begin
      cursor_column <= col_next;
      cursor_row    <= row_next;
      suspended     <= suspended_next;
      dirty         <= dirty_next;
    end
  end

  // output and spill valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spill_valid <= 1'b0;
    end else begin
      if (pop && n_res != 2'd0) out_valid <= 1'b1;
      else if (spill_valid && out_free) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;

      if (pop && n_res == 2'd2) spill_valid <= 1'b1;
      else if (spill_valid && out_free) spill_valid <= 1'b0;
    end
  end

  // output and spill words
  always_ff @(posedge clk) begin
    if (pop && n_res != 2'd0) out_res <= res0;
    else if (spill_valid && out_free) out_res <= spill_res;
    if (pop && n_res == 2'd2) spill_res <= res1;
  end

  `TCCE_ASSERT_NOW(a_spill_behind_out, spill_valid, out_valid, "spill word without output word")
  `TCCE_ASSERT_NOW(a_spill_blocks_queue, spill_valid, !q_ready, "queue popped while spill pending")
  `TCCE_ASSERT_NEXT(a_flush_clears, pop && q_op.code == OP_FLUSH, !dirty.valid, "dirty range kept after flush")

endmodule

>>> hdl/text_console_cursor_engine.sv
// Character-cell console cursor engine. Takes one input word per cycle
// (character, flush or suspend change) unless held by output back-pressure
// or a pending second result, and returns draw, scroll and flush commands.
// A printable character that wraps at the last column and scrolls gives two
// results and holds the back end until the second enters the output register,
// since the single output register is fed through a one-word spill stage.
// Words pass the input register, the four-word op queue, then the back end
// that updates the cursor and the dirty range and loads the output register.
// Config registers are written via their own channel, which is always ready.
`timescale 1ns / 1ps

module text_console_cursor_engine
  import tcce_pkg::*;
#(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 76,
  parameter int CELL_HEIGHT = 10,
  parameter int HEADER_ROWS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // char_code [7:0], suspend_on [8], zero fill
  input  logic [1:0]  s_tuser,   // func [1:0]
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // cell_column [6:0], cell_row [13:7],
                                 // glyph_index [20:14], range_top [30:21],
                                 // range_bottom [40:31], zero fill
  output logic [1:0]  m_tuser,   // kind [1:0]
  output logic        m_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  logic front_valid;
  logic front_ready;
  op_t  front_op;
  logic q_valid;
  logic q_ready;
  op_t  q_op;
  res_t res;

  // classify incoming words
  tcce_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .op_valid (front_valid),
    .op_ready (front_ready),
    .op       (front_op)
  );

  // decoupling queue
  tcce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_op     (front_op),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_op    (q_op)
  );

  // cursor state and result output
  tcce_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .CELL_HEIGHT (CELL_HEIGHT),
    .HEADER_ROWS (HEADER_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_op      (q_op),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_res     (res)
  );

  // pack the result word
  assign m_tdata = {7'b0, res.bottom, res.top, res.glyph, res.row, res.col};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule
